[sv/spd_pkg.sv]
// Shared types, constants and codes of the stroke point densifier.
`timescale 1ns / 1ps
package spd_pkg;

   // Coordinate and step count sizing
   localparam int COORD_BITS = 16;
   localparam int MAX_STEPS  = 64;

   // Thickness register
   localparam int              THICK_W     = 12;
   localparam logic [THICK_W-1:0] THICK_RESET = 12'd32;
   localparam logic [THICK_W-1:0] SPAN_MIN    = 12'd16;  // twice the least spacing

   // Derived widths
   localparam int MAG_W   = COORD_BITS;               // |delta| of one axis
   localparam int STEP_W  = $clog2(MAX_STEPS + 1);    // holds 0..MAX_STEPS
   localparam int SRCH_W  = $clog2(MAX_STEPS);        // holds 0..MAX_STEPS-1
   localparam int REM_W   = STEP_W + 1;               // remainders below 2*steps
   localparam int SS_W    = 2 * STEP_W;
   localparam int S2_W    = 2 * THICK_W;
   localparam int Q4_W    = 2 * MAG_W + 3;            // 4*(dx^2+dy^2)
   localparam int MUL_A_W = (MAG_W > SS_W) ? MAG_W : SS_W;
   localparam int MUL_B_W = (MAG_W > S2_W) ? MAG_W : S2_W;
   localparam int ALU_W   = (MUL_A_W + MUL_B_W > Q4_W + 1) ? (MUL_A_W + MUL_B_W) : (Q4_W + 1);
   localparam int CNT_W   = $clog2(MAG_W);

   // Command codes
   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_HIT   = 2'd2;

   // Shared unit operations
   localparam logic [1:0] ALU_MUL = 2'd0;
   localparam logic [1:0] ALU_ADD = 2'd1;
   localparam logic [1:0] ALU_SUB = 2'd2;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
   } req_data_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pt_x;
      logic signed [COORD_BITS-1:0] pt_y;
      logic                         hit;
      logic signed [COORD_BITS-1:0] box_min_x;
      logic signed [COORD_BITS-1:0] box_min_y;
      logic signed [COORD_BITS-1:0] box_max_x;
      logic signed [COORD_BITS-1:0] box_max_y;
      logic                         last_of_run;
      logic                         steps_clamped;
   } rsp_data_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             ge;
   } alu_rsp_type;

   typedef struct packed {
      logic load;
      logic advance;
   } interp_ctl_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] base;
      logic                         neg;
      logic [MAG_W-1:0]             qinc;
      logic [REM_W-1:0]             rinc;
      logic [STEP_W-1:0]            steps;
   } interp_load_type;

endpackage

[sv/stroke_point_densifier_unit.sv]
// Top level of the stroke point densifier: sequencer, state and output register.
`timescale 1ns / 1ps
// One input transfer is taken at a time; req_stall stays high until its last
// result has been loaded into the output register. Begin, hit tests and the
// first add of all load their result from the decode state, and unused
// commands return to idle without one. An add that needs no interpolation
// runs the spacing test and emits its point; an interpolated add runs the
// spacing test, the saturation probe, the step search (6 bits at 64 steps),
// the division of each axis at one quotient bit per cycle, then emits one
// point per cycle while the output does not stall. A run that saturates at
// MAX_STEPS skips the search. The spacing test, probe, search and division
// all run through the one shared multiply/add/compare unit; a stalled output holds the block.
module stroke_point_densifier_unit
   import spd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_data_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_data_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [THICK_W-1:0] csr_wr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SQ_Y   = 4'd2;
   localparam logic [3:0] S_SUM    = 4'd3;
   localparam logic [3:0] S_SP2    = 4'd4;
   localparam logic [3:0] S_NEAR   = 4'd5;
   localparam logic [3:0] S_PR_SQ  = 4'd6;
   localparam logic [3:0] S_PR_MUL = 4'd7;
   localparam logic [3:0] S_PR_CHK = 4'd8;
   localparam logic [3:0] S_SEARCH = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;

   // Control and model state (reset)
   logic [3:0]                   state_ff, state_in;
   logic [THICK_W-1:0]           thick_ff, thick_in;
   logic                         has_pt_ff, has_pt_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [COORD_BITS-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Working registers (no reset)
   logic [1:0]                   cmd_ff, cmd_in;
   logic signed [COORD_BITS-1:0] lat_x_ff, lat_x_in, lat_y_ff, lat_y_in;
   logic [MAG_W-1:0]             mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                         neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [ALU_W-1:0]             acc_ff, acc_in, tmp_ff, tmp_in;
   logic [ALU_W-1:0]             d4_ff, d4_in, s2_ff, s2_in;
   logic [STEP_W-1:0]            probe_ff, probe_in;
   logic                         first_ff, first_in;
   logic [SRCH_W-1:0]            lo_ff, lo_in, bit_ff, bit_in;
   logic [STEP_W-1:0]            steps_ff, steps_in;
   logic                         clamp_ff, clamp_in;
   logic [MAG_W-1:0]             div_num_ff, div_num_in, div_quo_ff, div_quo_in;
   logic [STEP_W-1:0]            div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]             div_cnt_ff, div_cnt_in;
   logic                         div_axis_ff, div_axis_in;
   logic [MAG_W-1:0]             qx_ff, qx_in;
   logic [REM_W-1:0]             rx_ff, rx_in;
   logic [STEP_W-1:0]            idx_ff, idx_in;
   rsp_data_type                 rsp_data_ff, rsp_data_in;

   // Combinational helpers
   alu_req_type                  alu_req;
   alu_rsp_type                  alu_rsp;
   interp_ctl_type               ictl;
   interp_load_type              ld_x, ld_y;
   logic signed [COORD_BITS-1:0] ix_coord, iy_coord;
   logic                         out_free, out_load;
   logic signed [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS:0]          ndx, ndy;
   logic [MAG_W-1:0]             mag_x_c, mag_y_c;
   logic [THICK_W-1:0]           span;
   logic signed [COORD_BITS-1:0] cand_x, cand_y;
   logic signed [COORD_BITS-1:0] wmin_x, wmin_y, wmax_x, wmax_y;
   logic [SRCH_W-1:0]            cand_s;
   logic [STEP_W:0]              div_trial;
   logic [STEP_W-1:0]            rem_next;
   logic [MAG_W-1:0]             quo_next;
   logic                         hit_c;

   spd_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   spd_interp u_interp_x (
      .clock (clock),
      .ctl   (ictl),
      .ld    (ld_x),
      .coord (ix_coord)
   );

   spd_interp u_interp_y (
      .clock (clock),
      .ctl   (ictl),
      .ld    (ld_y),
      .coord (iy_coord)
   );

   // Deltas, magnitudes and span from live registers
   always_comb begin
      dx      = {lat_x_ff[COORD_BITS-1], lat_x_ff} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
      dy      = {lat_y_ff[COORD_BITS-1], lat_y_ff} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
      ndx     = (COORD_BITS+1)'(0) - dx;
      ndy     = (COORD_BITS+1)'(0) - dy;
      mag_x_c = dx[COORD_BITS] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
      mag_y_c = dy[COORD_BITS] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
      span    = (thick_ff < SPAN_MIN) ? SPAN_MIN : thick_ff;
   end

   // Box widening and hit test
   always_comb begin
      cand_x = (state_ff == S_EMIT) ? ix_coord : lat_x_ff;
      cand_y = (state_ff == S_EMIT) ? iy_coord : lat_y_ff;
      wmin_x = (cand_x < min_x_ff) ? cand_x : min_x_ff;
      wmin_y = (cand_y < min_y_ff) ? cand_y : min_y_ff;
      wmax_x = (cand_x > max_x_ff) ? cand_x : max_x_ff;
      wmax_y = (cand_y > max_y_ff) ? cand_y : max_y_ff;
      hit_c  = (lat_x_ff >= min_x_ff) && (lat_x_ff <= max_x_ff) &&
               (lat_y_ff >= min_y_ff) && (lat_y_ff <= max_y_ff);
   end

   // Division step on the shared unit
   always_comb begin
      div_trial = {div_rem_ff, div_num_ff[MAG_W-1]};
      rem_next  = alu_rsp.ge ? alu_rsp.res[STEP_W-1:0] : div_trial[STEP_W-1:0];
      quo_next  = {div_quo_ff[MAG_W-2:0], alu_rsp.ge};
      cand_s    = lo_ff | bit_ff;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      thick_in    = csr_wr_en ? csr_wr_data : thick_ff;
      has_pt_in   = has_pt_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      min_x_in    = min_x_ff;
      min_y_in    = min_y_ff;
      max_x_in    = max_x_ff;
      max_y_in    = max_y_ff;
      cmd_in      = cmd_ff;
      lat_x_in    = lat_x_ff;
      lat_y_in    = lat_y_ff;
      mag_x_in    = mag_x_ff;
      mag_y_in    = mag_y_ff;
      neg_x_in    = neg_x_ff;
      neg_y_in    = neg_y_ff;
      acc_in      = acc_ff;
      tmp_in      = tmp_ff;
      d4_in       = d4_ff;
      s2_in       = s2_ff;
      probe_in    = probe_ff;
      first_in    = first_ff;
      lo_in       = lo_ff;
      bit_in      = bit_ff;
      steps_in    = steps_ff;
      clamp_in    = clamp_ff;
      div_num_in  = div_num_ff;
      div_quo_in  = div_quo_ff;
      div_rem_in  = div_rem_ff;
      div_cnt_in  = div_cnt_ff;
      div_axis_in = div_axis_ff;
      qx_in       = qx_ff;
      rx_in       = rx_ff;
      idx_in      = idx_ff;
      rsp_data_in = rsp_data_ff;
      out_load    = 1'b0;
      alu_req     = '{op: ALU_ADD, a: '0, b: '0};
      ictl        = '{load: 1'b0, advance: 1'b0};
      ld_x        = '{base: prev_x_ff, neg: neg_x_ff, qinc: qx_ff, rinc: rx_ff,
                      steps: steps_ff};
      ld_y        = '{base: prev_y_ff, neg: neg_y_ff, qinc: quo_next,
                      rinc: {rem_next, 1'b0}, steps: steps_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               lat_x_in = req_data.pos_x;
               lat_y_in = req_data.pos_y;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            unique case (cmd_ff)
               CMD_BEGIN: begin
                  if (out_free) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{pt_x: lat_x_ff, pt_y: lat_y_ff, hit: 1'b0,
                                     box_min_x: lat_x_ff, box_min_y: lat_y_ff,
                                     box_max_x: lat_x_ff, box_max_y: lat_y_ff,
                                     last_of_run: 1'b1, steps_clamped: 1'b0};
                     prev_x_in   = lat_x_ff;
                     prev_y_in   = lat_y_ff;
                     has_pt_in   = 1'b1;
                     min_x_in    = lat_x_ff;
                     max_x_in    = lat_x_ff;
                     min_y_in    = lat_y_ff;
                     max_y_in    = lat_y_ff;
                     state_in    = S_IDLE;
                  end
               end
               CMD_HIT: begin
                  if (out_free) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{pt_x: prev_x_ff, pt_y: prev_y_ff, hit: hit_c,
                                     box_min_x: min_x_ff, box_min_y: min_y_ff,
                                     box_max_x: max_x_ff, box_max_y: max_y_ff,
                                     last_of_run: 1'b1, steps_clamped: 1'b0};
                     state_in    = S_IDLE;
                  end
               end
               CMD_ADD: begin
                  if (!has_pt_ff) begin
                     // First point of all: stored as is, box widened
                     if (out_free) begin
                        out_load    = 1'b1;
                        rsp_data_in = '{pt_x: lat_x_ff, pt_y: lat_y_ff, hit: 1'b0,
                                        box_min_x: wmin_x, box_min_y: wmin_y,
                                        box_max_x: wmax_x, box_max_y: wmax_y,
                                        last_of_run: 1'b1, steps_clamped: 1'b0};
                        prev_x_in   = lat_x_ff;
                        prev_y_in   = lat_y_ff;
                        has_pt_in   = 1'b1;
                        min_x_in    = wmin_x;
                        min_y_in    = wmin_y;
                        max_x_in    = wmax_x;
                        max_y_in    = wmax_y;
                        state_in    = S_IDLE;
                     end
                  end else begin
                     alu_req  = '{op: ALU_MUL, a: ALU_W'(mag_x_c), b: ALU_W'(mag_x_c)};
                     acc_in   = alu_rsp.res;
                     mag_x_in = mag_x_c;
                     mag_y_in = mag_y_c;
                     neg_x_in = dx[COORD_BITS];
                     neg_y_in = dy[COORD_BITS];
                     state_in = S_SQ_Y;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_SQ_Y: begin
            alu_req  = '{op: ALU_MUL, a: ALU_W'(mag_y_ff), b: ALU_W'(mag_y_ff)};
            tmp_in   = alu_rsp.res;
            state_in = S_SUM;
         end

         S_SUM: begin
            alu_req  = '{op: ALU_ADD, a: acc_ff, b: tmp_ff};
            d4_in    = alu_rsp.res << 2;
            state_in = S_SP2;
         end

         S_SP2: begin
            alu_req  = '{op: ALU_MUL, a: ALU_W'(span), b: ALU_W'(span)};
            s2_in    = alu_rsp.res;
            state_in = S_NEAR;
         end

         S_NEAR: begin
            // Span squared against four times the squared distance
            alu_req  = '{op: ALU_SUB, a: s2_ff, b: d4_ff};
            clamp_in = 1'b0;
            if (alu_rsp.ge) begin
               // Close enough: a single step emits the sample itself
               steps_in  = STEP_W'(1);
               ictl.load = 1'b1;
               ld_x      = '{base: prev_x_ff, neg: neg_x_ff, qinc: mag_x_ff, rinc: '0,
                             steps: STEP_W'(1)};
               ld_y      = '{base: prev_y_ff, neg: neg_y_ff, qinc: mag_y_ff, rinc: '0,
                             steps: STEP_W'(1)};
               idx_in    = STEP_W'(1);
               state_in  = S_EMIT;
            end else begin
               probe_in = STEP_W'(MAX_STEPS);
               first_in = 1'b1;
               state_in = S_PR_SQ;
            end
         end

         S_PR_SQ: begin
            alu_req  = '{op: ALU_MUL, a: ALU_W'(probe_ff), b: ALU_W'(probe_ff)};
            tmp_in   = alu_rsp.res;
            state_in = S_PR_MUL;
         end

         S_PR_MUL: begin
            alu_req  = '{op: ALU_MUL, a: tmp_ff, b: s2_ff};
            tmp_in   = alu_rsp.res;
            state_in = S_PR_CHK;
         end

         S_PR_CHK: begin
            // ge: probe^2 * span^2 covers four times the squared distance
            alu_req = '{op: ALU_SUB, a: tmp_ff, b: d4_ff};
            if (first_ff) begin
               first_in = 1'b0;
               if (!alu_rsp.ge) begin
                  clamp_in    = 1'b1;
                  steps_in    = STEP_W'(MAX_STEPS);
                  div_num_in  = mag_x_ff;
                  div_rem_in  = '0;
                  div_quo_in  = '0;
                  div_cnt_in  = '0;
                  div_axis_in = 1'b0;
                  state_in    = S_DIV;
               end else begin
                  lo_in    = '0;
                  bit_in   = SRCH_W'(1) << (SRCH_W - 1);
                  state_in = S_SEARCH;
               end
            end else begin
               if (!alu_rsp.ge) begin
                  lo_in = probe_ff[SRCH_W-1:0];
               end
               bit_in   = bit_ff >> 1;
               state_in = S_SEARCH;
            end
         end

         S_SEARCH: begin
            // Largest count that falls short, built one bit at a time
            if (bit_ff == '0) begin
               steps_in    = STEP_W'(lo_ff) + STEP_W'(1);
               div_num_in  = mag_x_ff;
               div_rem_in  = '0;
               div_quo_in  = '0;
               div_cnt_in  = '0;
               div_axis_in = 1'b0;
               state_in    = S_DIV;
            end else if (STEP_W'(cand_s) >= STEP_W'(MAX_STEPS)) begin
               bit_in = bit_ff >> 1;
            end else begin
               probe_in = STEP_W'(cand_s);
               state_in = S_PR_SQ;
            end
         end

         S_DIV: begin
            // Restoring division of |delta| by the step count, one bit a cycle
            alu_req    = '{op: ALU_SUB, a: ALU_W'(div_trial), b: ALU_W'(steps_ff)};
            div_rem_in = rem_next;
            div_quo_in = quo_next;
            div_num_in = div_num_ff << 1;
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == CNT_W'(MAG_W - 1)) begin
               if (!div_axis_ff) begin
                  qx_in       = quo_next;
                  rx_in       = {rem_next, 1'b0};
                  div_num_in  = mag_y_ff;
                  div_rem_in  = '0;
                  div_quo_in  = '0;
                  div_cnt_in  = '0;
                  div_axis_in = 1'b1;
               end else begin
                  ictl.load = 1'b1;
                  idx_in    = STEP_W'(1);
                  state_in  = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               ictl.advance = 1'b1;
               rsp_data_in  = '{pt_x: ix_coord, pt_y: iy_coord, hit: 1'b0,
                                box_min_x: wmin_x, box_min_y: wmin_y,
                                box_max_x: wmax_x, box_max_y: wmax_y,
                                last_of_run: (idx_ff == steps_ff),
                                steps_clamped: clamp_ff};
               prev_x_in    = ix_coord;
               prev_y_in    = iy_coord;
               min_x_in     = wmin_x;
               min_y_in     = wmin_y;
               max_x_in     = wmax_x;
               max_y_in     = wmax_y;
               idx_in       = idx_ff + STEP_W'(1);
               if (idx_ff == steps_ff) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thick_ff     <= THICK_RESET;
         has_pt_ff    <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         min_x_ff     <= '0;
         min_y_ff     <= '0;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thick_ff     <= thick_in;
         has_pt_ff    <= has_pt_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      lat_x_ff    <= lat_x_in;
      lat_y_ff    <= lat_y_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
      d4_ff       <= d4_in;
      s2_ff       <= s2_in;
      probe_ff    <= probe_in;
      first_ff    <= first_in;
      lo_ff       <= lo_in;
      bit_ff      <= bit_in;
      steps_ff    <= steps_in;
      clamp_ff    <= clamp_in;
      div_num_ff  <= div_num_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_cnt_ff  <= div_cnt_in;
      div_axis_ff <= div_axis_in;
      qx_ff       <= qx_in;
      rx_ff       <= rx_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/spd_alu.sv]
// Shared multiply / add / subtract-compare unit of the densifier sequencer.
`timescale 1ns / 1ps
module spd_alu
   import spd_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [MUL_A_W+MUL_B_W-1:0] prod;

   // Narrow multiply on the low operand bits
   assign prod = req.a[MUL_A_W-1:0] * req.b[MUL_B_W-1:0];

   always_comb begin
      rsp.ge = (req.a >= req.b);
      unique case (req.op)
         ALU_MUL: rsp.res = ALU_W'(prod);
         ALU_ADD: rsp.res = req.a + req.b;
         ALU_SUB: rsp.res = req.a - req.b;
         default: rsp.res = '0;
      endcase
   end

endmodule

[sv/spd_interp.sv]
// One axis of the point interpolator: quotient/remainder accumulator.
`timescale 1ns / 1ps
module spd_interp
   import spd_pkg::*;
(
   input  logic                         clock,
   input  interp_ctl_type               ctl,
   input  interp_load_type              ld,
   output logic signed [COORD_BITS-1:0] coord
);

   // Invariant: 2*i*a + s == q*2s + r, with 0 <= r < 2s
   logic signed [COORD_BITS-1:0] base_ff;
   logic                         neg_ff;
   logic [MAG_W-1:0]             qinc_ff;
   logic [REM_W-1:0]             rinc_ff;
   logic [REM_W-1:0]             two_s_ff;
   logic [MAG_W-1:0]             q_ff;
   logic [REM_W-1:0]             r_ff;

   logic [REM_W:0]               r_sum;
   logic                         carry;
   logic [REM_W-1:0]             r_next;
   logic [MAG_W-1:0]             q_next;
   logic [COORD_BITS-1:0]        offs;

   // Next point of the run
   always_comb begin
      r_sum  = {1'b0, r_ff} + {1'b0, rinc_ff};
      carry  = (r_sum >= {1'b0, two_s_ff});
      r_next = carry ? REM_W'(r_sum - {1'b0, two_s_ff}) : r_sum[REM_W-1:0];
      q_next = q_ff + qinc_ff + MAG_W'(carry);
      offs   = neg_ff ? (COORD_BITS'(0) - COORD_BITS'(q_next)) : COORD_BITS'(q_next);
      coord  = $signed(COORD_BITS'(base_ff) + offs);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         base_ff  <= ld.base;
         neg_ff   <= ld.neg;
         qinc_ff  <= ld.qinc;
         rinc_ff  <= ld.rinc;
         two_s_ff <= {ld.steps, 1'b0};
         q_ff     <= '0;
         r_ff     <= REM_W'(ld.steps);
      end else if (ctl.advance) begin
         q_ff     <= q_next;
         r_ff     <= r_next;
      end
   end

endmodule

[sv/spd_checker.sv]
// Port-level assertions for the stroke point densifier, bound to the top level.
`timescale 1ns / 1ps
module spd_checker
   import spd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rsp_data_type       rsp_data
);

   // One input at a time: an accepted transfer blocks the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted back to back");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // A hit result is always the last of its run and never clamped
   a_hit_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.last_of_run && !rsp_data.steps_clamped))
      else $error("hit flag on a multi-point result");

   // The box never inverts
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($signed(rsp_data.box_min_x) <= $signed(rsp_data.box_max_x)) &&
                     ($signed(rsp_data.box_min_y) <= $signed(rsp_data.box_max_y))))
      else $error("bounding box inverted");

endmodule

bind stroke_point_densifier_unit spd_checker u_spd_checker (.*);

[bench/stroke_point_checker.sv]
// Channel monitor for the stroke point densifier: predicts emitted points and compares them.
`timescale 1ns / 1ps
module stroke_point_checker
   import spd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_data_type       req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_data_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [THICK_W-1:0] csr_wr_data,
   output int                 mismatch_count,
   output int                 points_owed
);

   localparam int PRINT_CAP = 200;

   // Predicted block state
   logic [THICK_W-1:0]           thick;
   logic signed [COORD_BITS-1:0] last_x, last_y;
   logic signed [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
   logic                         have_point;

   // Points owed by the block, oldest first
   rsp_data_type owed_points[$];

   initial begin
      mismatch_count = 0;
      points_owed    = 0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Rounded n / s, nearest, ties away from zero
   function automatic longint round_div(input longint n, input longint s);
      if (n >= 0)
         return (2 * n + s) / (2 * s);
      return -((2 * (-n) + s) / (2 * s));
   endfunction

   // Queue one point; a stored point also becomes the last point and widens the box
   task automatic emit_point(input longint x, input longint y, input logic hit_flag,
                             input logic last_flag, input logic clamp_flag,
                             input logic store);
      rsp_data_type p;
      if (store) begin
         if (x < lo_x) lo_x = COORD_BITS'(x);
         if (y < lo_y) lo_y = COORD_BITS'(y);
         if (x > hi_x) hi_x = COORD_BITS'(x);
         if (y > hi_y) hi_y = COORD_BITS'(y);
         last_x = COORD_BITS'(x);
         last_y = COORD_BITS'(y);
      end
      p.pt_x          = COORD_BITS'(x);
      p.pt_y          = COORD_BITS'(y);
      p.hit           = hit_flag;
      p.box_min_x     = lo_x;
      p.box_min_y     = lo_y;
      p.box_max_x     = hi_x;
      p.box_max_y     = hi_y;
      p.last_of_run   = last_flag;
      p.steps_clamped = clamp_flag;
      owed_points.push_back(p);
   endtask

   task automatic predict_points(input req_data_type item);
      longint px, py, dx, dy, dist4, span, span2, lx, ly, s, steps, i;
      logic   clamp;
      px = longint'(item.pos_x);
      py = longint'(item.pos_y);
      case (item.cmd)
         CMD_BEGIN: begin
            lo_x = item.pos_x; hi_x = item.pos_x;
            lo_y = item.pos_y; hi_y = item.pos_y;
            have_point = 1'b1;
            emit_point(px, py, 1'b0, 1'b1, 1'b0, 1'b1);
         end
         CMD_HIT: begin
            emit_point(longint'(last_x), longint'(last_y),
                       px >= lo_x && px <= hi_x && py >= lo_y && py <= hi_y,
                       1'b1, 1'b0, 1'b0);
         end
         CMD_ADD: begin
            dx    = px - last_x;
            dy    = py - last_y;
            dist4 = 4 * (dx * dx + dy * dy);
            span  = longint'((thick < SPAN_MIN) ? SPAN_MIN : thick);
            span2 = span * span;
            if (!have_point || dist4 <= span2) begin
               // first point of all, or close enough to take as it is
               have_point = 1'b1;
               emit_point(px, py, 1'b0, 1'b1, 1'b0, 1'b1);
            end else begin
               // least step count that keeps points within the spacing
               s = 1;
               while (s <= MAX_STEPS && s * s * span2 < dist4)
                  s++;
               clamp = (s > MAX_STEPS);
               steps = clamp ? MAX_STEPS : s;
               lx = longint'(last_x);
               ly = longint'(last_y);
               for (i = 1; i <= steps; i++)
                  emit_point(lx + round_div(i * dx, steps), ly + round_div(i * dy, steps),
                             1'b0, i == steps, clamp, 1'b1);
            end
         end
         default: ;  // unused command: nothing comes out
      endcase
   endtask

   task automatic compare_field(input string name, input longint got, input longint want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   task automatic compare_point(input rsp_data_type want);
      compare_field("pt_x", rsp_data.pt_x, want.pt_x);
      compare_field("pt_y", rsp_data.pt_y, want.pt_y);
      compare_field("hit", rsp_data.hit, want.hit);
      compare_field("box_min_x", rsp_data.box_min_x, want.box_min_x);
      compare_field("box_min_y", rsp_data.box_min_y, want.box_min_y);
      compare_field("box_max_x", rsp_data.box_max_x, want.box_max_x);
      compare_field("box_max_y", rsp_data.box_max_y, want.box_max_y);
      compare_field("last_of_run", rsp_data.last_of_run, want.last_of_run);
      compare_field("steps_clamped", rsp_data.steps_clamped, want.steps_clamped);
   endtask

   // Watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         thick      = THICK_RESET;
         last_x     = '0;
         last_y     = '0;
         lo_x       = '0;
         lo_y       = '0;
         hi_x       = '0;
         hi_y       = '0;
         have_point = 1'b0;
         owed_points.delete();
      end else begin
         if (csr_wr_en)
            thick = csr_wr_data;
         if (req_valid && !req_stall)
            predict_points(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (owed_points.size() == 0)
               report_mismatch("result transfer with no point owed");
            else
               compare_point(owed_points.pop_front());
         end
      end
      points_owed = owed_points.size();
   end

endmodule

[bench/tb_stroke_point_densifier_unit.sv]
// Testbench top for the stroke point densifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_stroke_point_densifier_unit;
   import spd_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 150;      // beyond the slowest single item
   localparam int         HOLD_CYCLES   = 400;
   localparam int         PHASE_ITEMS   = 56;
   localparam int         CYCLE_LIMIT   = 1000000;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_data_type       req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_data_type       rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [THICK_W-1:0] csr_wr_data = '0;

   int mismatch_count;
   int points_owed;

   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;

   // Pen position as the stimulus sees it
   longint pen_x = 0;
   longint pen_y = 0;

   stroke_point_densifier_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stroke_point_checker point_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .points_owed    (points_owed)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_stroke_point_densifier_unit NOT OK");
      $finish;
   end

   // Result side: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 29);
         end
      end
   end

   function automatic longint clip(input longint v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   function automatic longint rand_coord();
      logic signed [COORD_BITS-1:0] v;
      v = COORD_BITS'($urandom);
      return longint'(v);
   endfunction

   function automatic longint wobble(input longint span);
      return longint'($urandom_range(32'(2 * span))) - span;
   endfunction

   // One input transfer, with random idle cycles ahead of it
   task automatic send_item(input logic [1:0] cmd, input longint x, input longint y);
      req_data_type item;
      while (idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.cmd   = cmd;
      item.pos_x = COORD_BITS'(x);
      item.pos_y = COORD_BITS'(y);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_BEGIN || cmd == CMD_ADD) begin
         pen_x = x;
         pen_y = y;
      end
   endtask

   // Stop offering, wait for every owed point, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_thickness(input logic [THICK_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly strokes of adds around the pen, some hit tests, some noise
   task automatic random_item();
      longint reach;
      int     pick;
      case ($urandom_range(3))
         0: reach = 8;
         1: reach = 64;
         2: reach = 600;
         default: reach = 6000;
      endcase
      pick = $urandom_range(99);
      if (pick < 8)
         send_item(CMD_BEGIN, rand_coord(), rand_coord());
      else if (pick < 70)
         send_item(CMD_ADD, clip(pen_x + wobble(reach)), clip(pen_y + wobble(reach)));
      else if (pick < 76)
         send_item(CMD_ADD, rand_coord(), rand_coord());
      else if (pick < 94)
         send_item(CMD_HIT, clip(pen_x + wobble(2 * reach)), clip(pen_y + wobble(2 * reach)));
      else if (pick < 97)
         send_item(CMD_HIT, rand_coord(), rand_coord());
      else
         send_item(CMD_UNUSED, rand_coord(), rand_coord());
   endtask

   initial begin : stimulus
      logic [THICK_W-1:0] settings[6];
      settings = '{12'd0, 12'd4095, 12'd17, 12'd1, 12'd2730, 12'd0};
      settings[5] = THICK_W'($urandom_range(4095));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset thickness
      send_item(CMD_HIT, 0, 0);              // box is still the reset point
      send_item(CMD_HIT, -1, 0);
      send_item(CMD_ADD, 100, -50);          // add with no earlier point
      send_item(CMD_ADD, 110, -44);          // inside the spacing
      send_item(CMD_ADD, 110, -44);          // zero distance
      send_item(CMD_ADD, 300, 100);          // interpolated
      send_item(CMD_HIT, 300, 100);          // box corners, inclusive
      send_item(CMD_HIT, 0, -50);
      send_item(CMD_HIT, 301, 100);
      send_item(CMD_HIT, 0, -51);
      send_item(CMD_UNUSED, 1234, -1234);    // ignored
      send_item(CMD_BEGIN, -32768, 32767);
      send_item(CMD_ADD, 32767, -32768);     // step count saturates
      send_item(CMD_ADD, -32768, -32768);
      send_item(CMD_BEGIN, 0, 0);
      send_item(CMD_ADD, -54, 0);            // rounding ties, negative side
      send_item(CMD_ADD, 0, 0);              // rounding ties, positive side
      send_item(CMD_ADD, -54, 54);
      send_item(CMD_BEGIN, 32767, 32767);
      send_item(CMD_HIT, 32767, 32767);
      send_item(CMD_HIT, -32768, -32768);
      send_item(CMD_BEGIN, -32768, -32768);
      send_item(CMD_HIT, -32768, -32768);
      send_item(CMD_HIT, 32767, -32768);
      settle();

      // Random phases, one thickness each
      foreach (settings[p]) begin
         write_thickness(settings[p]);
         idle_on = (p != 1);                 // one stretch with no idling at all
         if (p == 2)
            hold_request = 1'b1;             // long result hold-off, input keeps coming
         repeat (PHASE_ITEMS) random_item();
         settle();
      end

      idle_on = 1'b1;
      if (mismatch_count == 0 && points_owed == 0)
         $display("tb_stroke_point_densifier_unit OK");
      else
         $display("tb_stroke_point_densifier_unit NOT OK");
      $finish;
   end

endmodule
